// ----- hdl/arc_pkg.sv -----
// package with sizes, codes and entry layout of the address resolution cache
`default_nettype none

package arc_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  localparam int IP_W  = 32;
  localparam int MAC_W = 48;

  // packed stream widths
  localparam int IN_DATA_W  = IP_W + MAC_W;
  localparam int OUT_DATA_W = MAC_W;

  // operation codes
  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  // one table entry as stored in the memory
  typedef struct packed {
    logic [MAC_W-1:0] mac;
    logic [IP_W-1:0]  ip;
  } entry_t;

endpackage

`default_nettype wire

// ----- hdl/address_resolution_cache_core.sv -----
// Address resolution cache: a fully associative IPv4 to MAC table in one
// synchronous memory of ENTRIES rows. One transaction is taken at a time.
// The table fills from row 0 upward and never frees a row, so the valid rows
// are always rows 0 to count-1 and a fill count replaces per-row valid bits.
// Each transaction scans the valid rows through the memory's single read port,
// one row per cycle with a registered read, and stops at the first match. The
// next transaction is accepted only once the result has been loaded into the
// output register, so the scan through the read port sets the rate, and it is
// slowed further while an older result still waits in the output register.
// An add writes back its row in the cycle after the scan. Reset empties the
// table at once with no clearing pass.
`default_nettype none

module address_resolution_cache_core import arc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input channel
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // ip_address[31:0], mac_address[79:32]
  input  wire logic [0:0]            in_tuser,   // operation[0]
  // result channel
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // found_mac[47:0]
  output logic [0:0]                 out_tuser   // status[0]
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESOLVE,
    S_DONE
  } state_t;

  // table memory and its registered read data
  entry_t mem [ENTRIES];
  entry_t mem_q;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0]   cmp_idx_r, cmp_idx_nxt;
  logic               pend_r, pend_nxt;
  logic               found_r, found_nxt;
  logic [IDX_W-1:0]   hit_idx_r, hit_idx_nxt;
  logic [MAC_W-1:0]   hit_mac_r, hit_mac_nxt;
  logic               op_r, op_nxt;
  logic [IP_W-1:0]    ip_r, ip_nxt;
  logic [MAC_W-1:0]   mac_r, mac_nxt;
  logic               res_status_r, res_status_nxt;
  logic [MAC_W-1:0]   res_mac_r, res_mac_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_status_r, out_status_nxt;
  logic [MAC_W-1:0]   out_mac_r, out_mac_nxt;

  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             wr_data;

  logic               in_fire;
  logic               out_free;
  logic               cmp_hit;
  logic               more_rows;
  logic               res_status;
  logic [MAC_W-1:0]   res_mac;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_mac_r;
  assign out_tuser  = out_status_r;

  // compare the row read in the previous cycle
  assign cmp_hit   = pend_r && (mem_q.ip == ip_r);
  assign more_rows = (rd_idx_r < count_r);

  // result of the finished scan
  always_comb begin
    res_status = STATUS_FAIL;
    res_mac    = '0;
    if (op_r == OP_LOOKUP) begin
      if (found_r) begin
        res_status = STATUS_OK;
        res_mac    = hit_mac_r;
      end
    end else if (found_r || (count_r < CNT_W'(ENTRIES))) begin
      res_status = STATUS_OK;
    end
  end

  // next state and datapath
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    rd_idx_nxt     = rd_idx_r;
    cmp_idx_nxt    = cmp_idx_r;
    pend_nxt       = pend_r;
    found_nxt      = found_r;
    hit_idx_nxt    = hit_idx_r;
    hit_mac_nxt    = hit_mac_r;
    op_nxt         = op_r;
    ip_nxt         = ip_r;
    mac_nxt        = mac_r;
    res_status_nxt = res_status_r;
    res_mac_nxt    = res_mac_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_mac_nxt    = out_mac_r;
    rd_en          = 1'b0;
    rd_addr        = rd_idx_r[IDX_W-1:0];
    wr_en          = 1'b0;
    wr_addr        = hit_idx_r;
    wr_data.ip     = ip_r;
    wr_data.mac    = mac_r;

    // result register drains on its own handshake
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt     = in_tuser[0];
          ip_nxt     = in_tdata[IP_W-1:0];
          mac_nxt    = in_tdata[IP_W +: MAC_W];
          rd_idx_nxt = '0;
          pend_nxt   = 1'b0;
          found_nxt  = 1'b0;
          state_nxt  = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cmp_hit) begin
          found_nxt   = 1'b1;
          hit_idx_nxt = cmp_idx_r;
          hit_mac_nxt = mem_q.mac;
          pend_nxt    = 1'b0;
          state_nxt   = S_RESOLVE;
        end else if (more_rows) begin
          rd_en       = 1'b1;
          pend_nxt    = 1'b1;
          cmp_idx_nxt = rd_idx_r[IDX_W-1:0];
          rd_idx_nxt  = rd_idx_r + CNT_W'(1);
        end else if (pend_r) begin
          pend_nxt = 1'b0;
        end else begin
          state_nxt = S_RESOLVE;
        end
      end
      S_RESOLVE: begin
        // add: update the matching row or fill the next free one
        if (op_r == OP_ADD) begin
          if (found_r) begin
            wr_en = 1'b1;
          end else if (count_r < CNT_W'(ENTRIES)) begin
            wr_en     = 1'b1;
            wr_addr   = count_r[IDX_W-1:0];
            count_nxt = count_r + CNT_W'(1);
          end
        end
        res_status_nxt = res_status;
        res_mac_nxt    = res_mac;
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status;
          out_mac_nxt    = res_mac;
          state_nxt      = S_IDLE;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_mac_nxt    = res_mac_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rd_idx_r     <= rd_idx_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    found_r      <= found_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_mac_r    <= hit_mac_nxt;
    op_r         <= op_nxt;
    ip_r         <= ip_nxt;
    mac_r        <= mac_nxt;
    res_status_r <= res_status_nxt;
    res_mac_r    <= res_mac_nxt;
    out_status_r <= out_status_nxt;
    out_mac_r    <= out_mac_nxt;
  end

  // table memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  // fill count never passes the table size
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(ENTRIES))
    else $error("fill count beyond table size");

  // the fill count moves only when an add resolves, by one row
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |->
      ($past(state_r) == S_RESOLVE && count_r == $past(count_r) + CNT_W'(1)))
    else $error("fill count changed outside an add");

  // the scan never reads beyond the filled rows
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> (rd_idx_r < count_r))
    else $error("scan read of an unfilled row");

  // memory reads and writes never overlap
  a_rw_split: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && wr_en))
    else $error("read and write in the same cycle");

  // a resolved transaction always reaches the result register
  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESOLVE && out_free) |=> out_valid_r)
    else $error("result not loaded after resolve");

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// testbench for the address resolution cache core: directed and random add/lookup traffic
`timescale 1ns / 1ps

module tb import arc_pkg::*; ();

  // expected reply for one request
  typedef struct packed {
    logic             status;
    logic [MAC_W-1:0] mac;
  } arc_reply_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // ip_address[31:0], mac_address[79:32]
  logic [0:0]            in_tuser = '0;   // operation[0]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // found_mac[47:0]
  logic [0:0]            out_tuser;       // status[0]

  // shadow copy of the table
  logic             table_valid [ENTRIES];
  logic [IP_W-1:0]  table_ip    [ENTRIES];
  logic [MAC_W-1:0] table_mac   [ENTRIES];

  arc_reply_t pending_replies[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int err_count      = 0;
  int sent_count     = 0;
  int reply_count    = 0;
  int hit_count      = 0;
  int miss_count     = 0;
  int update_count   = 0;
  int fill_count     = 0;
  int refused_count  = 0;

  address_resolution_cache_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // clock
  initial begin
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("tb: errors");
    $finish;
  end

  // lowest valid slot holding the address, or -1
  function automatic int find_entry(logic [IP_W-1:0] ip);
    int idx;
    idx = -1;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (table_valid[i] && table_ip[i] == ip) idx = i;
    end
    return idx;
  endfunction

  // number of occupied slots (always slots 0 upward)
  function automatic int occupied_slots();
    int n;
    n = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (table_valid[i]) n++;
    end
    return n;
  endfunction

  // apply one request to the shadow table and return its reply
  function automatic arc_reply_t resolve_request(logic op, logic [IP_W-1:0] ip,
                                                 logic [MAC_W-1:0] mac);
    arc_reply_t r;
    int hit;
    int free_slot;
    r.status = STATUS_FAIL;
    r.mac = '0;
    hit = find_entry(ip);
    if (op == OP_LOOKUP) begin
      if (hit >= 0) begin
        r.status = STATUS_OK;
        r.mac = table_mac[hit];
        hit_count++;
      end else begin
        miss_count++;
      end
    end else if (hit >= 0) begin
      table_mac[hit] = mac;
      r.status = STATUS_OK;
      update_count++;
    end else begin
      free_slot = -1;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
        if (!table_valid[i]) free_slot = i;
      end
      if (free_slot >= 0) begin
        table_valid[free_slot] = 1'b1;
        table_ip[free_slot] = ip;
        table_mac[free_slot] = mac;
        r.status = STATUS_OK;
        fill_count++;
      end else begin
        refused_count++;
      end
    end
    return r;
  endfunction

  function automatic logic [MAC_W-1:0] random_mac();
    logic [MAC_W-1:0] m;
    m[31:0] = $urandom();
    m[MAC_W-1:32] = 16'($urandom_range(16'hffff));
    return m;
  endfunction

  // mostly stored addresses, some one bit away, the rest anywhere
  function automatic logic [IP_W-1:0] pick_ip();
    int sel;
    int used;
    logic [IP_W-1:0] ip;
    sel = $urandom_range(99);
    used = occupied_slots();
    if (used > 0 && sel < 60) begin
      ip = table_ip[$urandom_range(used - 1)];
    end else if (used > 0 && sel < 70) begin
      ip = table_ip[$urandom_range(used - 1)] ^ (32'd1 << $urandom_range(IP_W - 1));
    end else begin
      ip = $urandom();
    end
    return ip;
  endfunction

  // drive one transaction, wait for acceptance, record its expected reply
  task automatic send_item(logic op, logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {mac, ip};
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    pending_replies.push_back(resolve_request(op, ip, mac));
    sent_count++;
  endtask

  // stop sending and wait for every outstanding reply
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  // receiver stalls
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // reply checker
  always @(posedge clk) begin
    arc_reply_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      reply_count++;
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected reply status=%0b mac=%012h", $time, out_tuser[0],
                 out_tdata);
        err_count++;
      end else begin
        exp_r = pending_replies.pop_front();
        if (out_tuser[0] !== exp_r.status) begin
          $display("%0t: status mismatch expected %0b actual %0b", $time, exp_r.status,
                   out_tuser[0]);
          err_count++;
        end
        if (out_tdata !== exp_r.mac) begin
          $display("%0t: mac mismatch expected %012h actual %012h", $time, exp_r.mac,
                   out_tdata);
          err_count++;
        end
      end
    end
  end

  // lookups on an empty table all miss
  task automatic test_empty_table();
    send_item(OP_LOOKUP, 32'h0000_0000, '0);
    send_item(OP_LOOKUP, 32'hffff_ffff, '1);
    wait_drained();
  endtask

  // extreme addresses, update, lookup ignores its mac field
  task automatic test_field_extremes();
    send_item(OP_ADD,    32'h0000_0000, '0);
    send_item(OP_ADD,    32'hffff_ffff, '1);
    send_item(OP_LOOKUP, 32'h0000_0000, '1);
    send_item(OP_LOOKUP, 32'hffff_ffff, '0);
    send_item(OP_ADD,    32'h0000_0000, 48'hffff_ffff_ffff);
    send_item(OP_LOOKUP, 32'h0000_0000, '0);
    send_item(OP_LOOKUP, 32'h8000_0000, '0);
    send_item(OP_ADD,    32'h8000_0000, 48'h8000_0000_0001);
    send_item(OP_LOOKUP, 32'h8000_0000, random_mac());
    wait_drained();
  endtask

  // fill what is left, then refused add, miss on it, update on a full table
  task automatic test_table_full();
    logic [IP_W-1:0] ip;
    while (occupied_slots() < ENTRIES) begin
      do ip = $urandom(); while (find_entry(ip) >= 0);
      send_item(OP_ADD, ip, random_mac());
    end
    do ip = $urandom(); while (find_entry(ip) >= 0);
    send_item(OP_ADD, ip, random_mac());
    send_item(OP_LOOKUP, ip, '0);
    send_item(OP_ADD, table_ip[ENTRIES-1], random_mac());
    send_item(OP_LOOKUP, table_ip[ENTRIES-1], '0);
    wait_drained();
  endtask

  // sender goes quiet until the pipeline is empty, then resumes
  task automatic test_sender_pause();
    repeat (6) send_item(1'($urandom_range(1)), pick_ip(), random_mac());
    wait_drained();
    repeat (6) send_item(1'($urandom_range(1)), pick_ip(), random_mac());
    wait_drained();
  endtask

  task automatic test_random_traffic(int idle_pct, int stall_pct, int count);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_item(1'($urandom_range(1)), pick_ip(), random_mac());
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      table_valid[i] = 1'b0;
      table_ip[i] = '0;
      table_mac[i] = '0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_field_extremes();
    test_random_traffic(0, 0, 420);
    test_table_full();
    test_sender_pause();
    test_random_traffic(75, 0, 420);
    test_random_traffic(0, 75, 420);
    test_random_traffic(22, 22, 420);

    recv_stall_pct = 0;
    repeat (40) @(posedge clk);
    $display("summary: %0d requests, %0d replies; lookups %0d hit / %0d missed", sent_count,
             reply_count, hit_count, miss_count);
    $display("summary: adds %0d updated / %0d filled / %0d refused on a full table",
             update_count, fill_count, refused_count);
    if (err_count == 0 && pending_replies.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
